// File: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MCEP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every clock edge, reset included
`define MCEP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: design/mcep_pkg.sv
// types, constants and helpers for the color expansion packer
`timescale 1ns / 1ps

package mcep_pkg;

    localparam int WORD_BITS = 32;
    localparam int LANES     = 8;

    localparam logic [1:0] REG_PIXEL_BITS = 2'd0;
    localparam logic [1:0] REG_FG_COLOR   = 2'd1;
    localparam logic [1:0] REG_BG_COLOR   = 2'd2;
    localparam logic [1:0] REG_MSB_FIRST  = 2'd3;

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [LANES-1:0][WORD_BITS-1:0] colors;
        logic [3:0]                      npix;
        logic                            line_start;
        logic                            line_end;
        logic [4:0]                      start_offset;
        word_t                           old_first_word;
        word_t                           old_last_word;
    } item_t;

    // pixel depth clamped to 1..32
    function automatic logic [5:0] eff_bpp(input logic [5:0] pb);
        logic [5:0] r;
        begin
            if (pb == 6'd0)
                r = 6'd1;
            else if (pb > 6'd32)
                r = 6'd32;
            else
                r = pb;
            return r;
        end
    endfunction

    function automatic word_t depth_mask(input logic [5:0] bpp);
        logic [5:0] sh;
        begin
            sh = 6'd32 - bpp;
            return ALL_ONES >> sh;
        end
    endfunction

endpackage

// File: design/mcep_lane.sv
// one pixel lane: picks and masks the color for one bitmap bit
`timescale 1ns / 1ps

module mcep_lane
(
    input  logic              bit_in,
    input  mcep_pkg::word_t   ink_color,
    input  mcep_pkg::word_t   paper_color,
    input  mcep_pkg::word_t   mask,
    output mcep_pkg::word_t   color
);

    assign color = (bit_in ? ink_color : paper_color) & mask;

endmodule

// File: design/mcep_packer.sv
// merge stage: packs lane colors into words, one pixel per cycle unless the output stalls
`timescale 1ns / 1ps

module mcep_packer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [5:0]          bpp,
    input  logic                msb_first,
    input  logic                item_valid,
    input  mcep_pkg::item_t     item,
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output mcep_pkg::word_t     out_word,
    output logic                line_done
);

    logic [mcep_pkg::LANES-1:0][mcep_pkg::WORD_BITS-1:0] colors_reg;
    logic [3:0]       idx_reg;
    logic [3:0]       npix_reg;
    logic             end_reg;
    logic             busy_reg;
    mcep_pkg::word_t  old_last_reg;
    mcep_pkg::word_t  accum_reg, accum_next;
    logic [4:0]       fill_reg, fill_next;
    logic             out_valid_reg;
    mcep_pkg::word_t  out_word_reg;
    logic             line_done_reg;

    logic             at_end;
    mcep_pkg::word_t  color_cur, placed, full_word, carry_word, merge_word, init_word;
    logic [63:0]      wide;
    logic [5:0]       sum;
    logic             spill, emit, emit_done, can_emit, stall, advance;
    mcep_pkg::word_t  emit_word;
    mcep_pkg::word_t  base_accum;
    logic [4:0]       base_fill;

    assign at_end    = (idx_reg == npix_reg);
    assign color_cur = colors_reg[idx_reg[2:0]];
    assign sum       = {1'b0, fill_reg} + bpp;
    assign spill     = sum[5];
    assign placed    = color_cur << (6'd32 - bpp);

    always_comb
    begin
        if (msb_first)
        begin
            wide       = {placed, 32'd0} >> fill_reg;
            full_word  = accum_reg | wide[63:32];
            carry_word = wide[31:0];
            merge_word = (old_last_reg & (mcep_pkg::ALL_ONES >> fill_reg)) | accum_reg;
        end
        else
        begin
            wide       = {32'd0, color_cur} << fill_reg;
            full_word  = accum_reg | wide[31:0];
            carry_word = wide[63:32];
            merge_word = (old_last_reg & (mcep_pkg::ALL_ONES << fill_reg)) | accum_reg;
        end
    end

    always_comb
    begin
        if (msb_first)
            init_word = item.old_first_word & ~(mcep_pkg::ALL_ONES >> item.start_offset);
        else
            init_word = item.old_first_word & ~(mcep_pkg::ALL_ONES << item.start_offset);
    end

    always_comb
    begin
        emit       = 1'b0;
        emit_done  = 1'b0;
        emit_word  = full_word;
        base_accum = accum_reg;
        base_fill  = fill_reg;
        if (busy_reg)
        begin
            if (!at_end)
            begin
                emit       = spill;
                emit_done  = end_reg && (idx_reg == npix_reg - 4'd1) && (sum[4:0] == 5'd0);
                base_accum = spill ? carry_word : full_word;
                base_fill  = sum[4:0];
            end
            else if (end_reg)
            begin
                // partial last word gets the old word's bits beyond the fill
                emit       = (fill_reg != 5'd0);
                emit_done  = 1'b1;
                emit_word  = merge_word;
                base_accum = '0;
                base_fill  = 5'd0;
            end
        end
    end

    assign can_emit = !out_valid_reg || out_ready;
    assign stall    = emit && !can_emit;
    assign advance  = busy_reg && !stall;
    assign take     = item_valid && (!busy_reg || (advance && at_end));

    always_comb
    begin
        accum_next = accum_reg;
        fill_next  = fill_reg;
        if (advance)
        begin
            accum_next = base_accum;
            fill_next  = base_fill;
        end
        if (take && item.line_start)
        begin
            accum_next = init_word;
            fill_next  = item.start_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            accum_reg     <= '0;
            fill_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg <= accum_next;
            fill_reg  <= fill_next;
            if (take)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end
            else if (advance)
            begin
                if (at_end)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 4'd1;
            end
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            colors_reg   <= item.colors;
            npix_reg     <= item.npix;
            end_reg      <= item.line_end;
            old_last_reg <= item.old_last_word;
        end
        if (advance && emit)
        begin
            out_word_reg  <= emit_word;
            line_done_reg <= emit_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign line_done = line_done_reg;

endmodule

// File: design/mono_color_expand_pack.sv
// top level: monochrome color expansion into packed destination words
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | bitmap_byte, valid_bits, line_start,
//           |                      | line_end, start_offset, old_first_word,
//           |                      | old_last_word
//  output   | out_valid/out_ready  | out_word, line_done
//  config   | cfg_we               | cfg_index, cfg_data
//
// eight lanes resolve the colors of an item in the cycle it is accepted;
// the packer then takes one pixel per cycle unless the output stalls, plus a
// closing step per item, and sends at most one word out per cycle
// reset clears the partial word, the fill position and all handshakes
// an item waits in the lane register while the packer works on the one before
// a stalled output holds the packer on the pixel that needs to emit
`timescale 1ns / 1ps

module mono_color_expand_pack
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   bitmap_byte,
    input  logic [3:0]   valid_bits,
    input  logic         line_start,
    input  logic         line_end,
    input  logic [4:0]   start_offset,
    input  logic [31:0]  old_first_word,
    input  logic [31:0]  old_last_word,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  out_word,
    output logic         line_done
);

    logic [5:0]       pixel_bits_reg;
    mcep_pkg::word_t  ink_color_reg;
    mcep_pkg::word_t  paper_color_reg;
    logic             msb_first_reg;

    logic [5:0]       bpp;
    mcep_pkg::word_t  mask;
    logic [mcep_pkg::LANES-1:0][mcep_pkg::WORD_BITS-1:0] lane_color;
    mcep_pkg::item_t  lane_item;
    mcep_pkg::item_t  stage_reg;
    logic             stage_valid_reg;
    logic             take;
    logic             in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bits_reg  <= 6'd8;
            ink_color_reg   <= '0;
            paper_color_reg <= '0;
            msb_first_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcep_pkg::REG_PIXEL_BITS: pixel_bits_reg  <= cfg_data[5:0];
                mcep_pkg::REG_FG_COLOR:   ink_color_reg   <= cfg_data;
                mcep_pkg::REG_BG_COLOR:   paper_color_reg <= cfg_data;
                mcep_pkg::REG_MSB_FIRST:  msb_first_reg   <= cfg_data[0];
                default:                  msb_first_reg   <= msb_first_reg;
            endcase
        end
    end

    assign bpp  = mcep_pkg::eff_bpp(pixel_bits_reg);
    assign mask = mcep_pkg::depth_mask(bpp);

    genvar g;
    generate
        for (g = 0; g < mcep_pkg::LANES; g++)
        begin : g_lane
            mcep_lane u_lane
            (
                .bit_in      (bitmap_byte[mcep_pkg::LANES-1-g]),
                .ink_color   (ink_color_reg),
                .paper_color (paper_color_reg),
                .mask        (mask),
                .color       (lane_color[g])
            );
        end
    endgenerate

    always_comb
    begin
        lane_item.colors         = lane_color;
        lane_item.npix           = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
        lane_item.line_start     = line_start;
        lane_item.line_end       = line_end;
        lane_item.start_offset   = start_offset;
        lane_item.old_first_word = old_first_word;
        lane_item.old_last_word  = old_last_word;
    end

    assign in_ready  = !stage_valid_reg || take;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_accept)
            stage_valid_reg <= 1'b1;
        else if (take)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            stage_reg <= lane_item;
    end

    mcep_packer u_packer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bpp        (bpp),
        .msb_first  (msb_first_reg),
        .item_valid (stage_valid_reg),
        .item       (stage_reg),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .line_done  (line_done)
    );

endmodule

// File: design/mcep_checker.sv
// port-level checks for the color expansion packer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcep_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [31:0]  out_word,
    input  logic         line_done
);

    // a stalled item keeps its word and flag
    `MCEP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(line_done))

    // the input side only closes right after taking an item
    `MCEP_ASSERT(a_ready_fall, clk, rst_n, $fell(in_ready) |-> $past(in_valid))

    // nothing is shown in the cycle reset ends
    `MCEP_ASSERT_ALWAYS(a_reset_quiet, clk, $rose(rst_n) |-> !out_valid)

endmodule

bind mono_color_expand_pack mcep_checker u_mcep_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .line_done (line_done)
);
